FILE: hw/rtl/apf_pkg.sv
// Shared types, constants and lookup functions for the Art-Net packet filter.
package apf_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 1024;
  localparam int unsigned MAX_SLOTS        = 512;
  localparam int unsigned HDR_BYTES        = 18;
  localparam int unsigned MIN_PKT_BYTES    = 12;
  localparam int unsigned POS_W            = 11;
  localparam int unsigned POS_LIMIT        = 2047;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [15:0] OPC_POLL   = 16'h2000;
  localparam logic [15:0] OPC_OUTPUT = 16'h5000;
  localparam logic [15:0] OPC_NZS    = 16'h5100;
  localparam logic [15:0] OPC_SYNC   = 16'h5200;

  localparam logic KIND_SLOT    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;
  localparam logic ACT_BYTE     = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_INVALID   = 3'd0,
    VERDICT_POLL      = 3'd1,
    VERDICT_SYNC      = 3'd2,
    VERDICT_OUTPUT_OK = 3'd3,
    VERDICT_NZS_OK    = 3'd4,
    VERDICT_BC_REFUSE = 3'd5,
    VERDICT_FIELD_REJ = 3'd6,
    VERDICT_OTHER     = 3'd7
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BCAST_ALLOWED = 2'd0,
    REG_MIN_VERSION   = 2'd1,
    REG_SYNC_TIMEOUT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic        bcast_allowed;
    logic [15:0] min_version;
    logic [15:0] sync_timeout;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       broadcast;
  } item_t;

  typedef struct packed {
    logic        kind;
    verdict_e    verdict;
    logic [14:0] universe_number;
    logic [9:0]  slot_count;
    logic [8:0]  slot_index;
    logic [7:0]  slot_value;
    logic        sync_pulse;
    logic        sync_mode;
  } res_t;

  // "Art-Net" plus terminating zero
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h72;
      3'd2:    b = 8'h74;
      3'd3:    b = 8'h2D;
      3'd4:    b = 8'h4E;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic opcode_known(input logic [15:0] op);
    logic k;
    case (op)
      16'h2000, 16'h2100, 16'h2300, 16'h2400, 16'h5000, 16'h5100, 16'h5200,
      16'h6000, 16'h7000, 16'h8000, 16'h8100, 16'h8200, 16'h8300, 16'h8400,
      16'hA010, 16'hA020, 16'hA040, 16'hF000, 16'hF100, 16'hF200, 16'hF300,
      16'hF400, 16'hF500, 16'hF600, 16'hF800, 16'hF900, 16'h9000, 16'h9100,
      16'h9200, 16'h9300, 16'h9700, 16'h9800, 16'h9900, 16'h9A00,
      16'h9B00: k = 1'b1;
      default:  k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/apf_cfg.sv
// Configuration register file of the Art-Net packet filter.
module apf_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [apf_pkg::CFG_IDX_W-1:0]       wr_index_i,
  input  logic [apf_pkg::CFG_DATA_W-1:0]      wr_data_i,
  output apf_pkg::cfg_t                       cfg_o
);
  import apf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_BCAST_ALLOWED: cfg_d.bcast_allowed = wr_data_i[0];
        REG_MIN_VERSION:   cfg_d.min_version   = wr_data_i;
        REG_SYNC_TIMEOUT:  cfg_d.sync_timeout  = wr_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bcast_allowed <= 1'b1;
      cfg_q.min_version   <= 16'd14;
      cfg_q.sync_timeout  <= 16'd4000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/apf_core.sv
// Packet parse state, header checks, slot stream and sync watchdog.
module apf_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  apf_pkg::item_t item_i,
  input  apf_pkg::cfg_t  cfg_i,
  output logic           res_valid_o,
  output apf_pkg::res_t  res_o
);
  import apf_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             sig_ok_q, sig_ok_d;
  logic [15:0]      op_q, op_d;
  logic [15:0]      ver_q, ver_d;
  logic [7:0]       sc_q, sc_d;
  logic [15:0]      uni_q, uni_d;
  logic [15:0]      len_q, len_d;
  logic             fed_q, fed_d;
  logic [15:0]      ticks_q, ticks_d;
  logic             mode_q, mode_d;

  logic [7:0]       b;
  logic [POS_W-1:0] rel;
  logic [POS_W:0]   total;
  logic             prefix_ok, refused, fields_ok, data_op, slot_here, starved;

  assign b     = item_i.data_byte;
  assign rel   = pos_q - POS_W'(HDR_BYTES);
  assign total = {1'b0, pos_q} + 1'b1;

  // header fields as they stand once this byte is folded in
  always_comb begin
    sig_ok_d = sig_ok_q;
    op_d     = op_q;
    ver_d    = ver_q;
    sc_d     = sc_q;
    uni_d    = uni_q;
    len_d    = len_q;
    if (pos_q < POS_W'(8)) begin
      if (b != sig_byte(pos_q[2:0])) sig_ok_d = 1'b0;
    end else begin
      case (pos_q)
        POS_W'(8):  op_d[7:0]   = b;
        POS_W'(9):  op_d[15:8]  = b;
        POS_W'(10): ver_d[15:8] = b;
        POS_W'(11): ver_d[7:0]  = b;
        POS_W'(13): sc_d        = b;
        POS_W'(14): uni_d[7:0]  = b;
        POS_W'(15): uni_d[15:8] = b;
        POS_W'(16): len_d[15:8] = b;
        POS_W'(17): len_d[7:0]  = b;
        default: ;
      endcase
    end
  end

  assign prefix_ok = sig_ok_d && opcode_known(op_d) && (ver_d >= cfg_i.min_version);
  assign refused   = item_i.broadcast && !cfg_i.bcast_allowed;
  assign data_op   = (op_d == OPC_OUTPUT) || (op_d == OPC_NZS);
  assign fields_ok = (len_d >= 16'd2) && (len_d <= 16'(MAX_SLOTS)) && !len_d[0] &&
                     !uni_d[15] && !((op_d == OPC_NZS) && (sc_d != 8'd0));
  assign slot_here = (pos_q >= POS_W'(HDR_BYTES)) && prefix_ok && data_op && !refused &&
                     fields_ok && ({5'd0, rel} < len_d);
  assign starved   = !fed_q || (ticks_q > cfg_i.sync_timeout);

  always_comb begin
    pos_d       = pos_q;
    fed_d       = fed_q;
    ticks_d     = ticks_q;
    mode_d      = mode_q;
    res_valid_o = 1'b0;
    res_o.kind            = KIND_SLOT;
    res_o.verdict         = VERDICT_INVALID;
    res_o.universe_number = uni_d[14:0];
    res_o.slot_count      = len_d[9:0];
    res_o.slot_index      = slot_here ? rel[8:0] : 9'd0;
    res_o.slot_value      = slot_here ? b : 8'd0;
    res_o.sync_pulse      = 1'b0;

    if (item_i.action == ACT_TICK) begin
      if (ticks_q != 16'hFFFF) ticks_d = ticks_q + 16'd1;
    end else if (!item_i.last_byte) begin
      if (pos_q != POS_W'(POS_LIMIT)) pos_d = pos_q + 1'b1;
      res_valid_o = slot_here;
    end else begin
      pos_d                 = '0;
      res_valid_o           = 1'b1;
      res_o.kind            = KIND_VERDICT;
      res_o.universe_number = '0;
      res_o.slot_count      = '0;
      if (total < (POS_W+1)'(MIN_PKT_BYTES) || total > (POS_W+1)'(MAX_PACKET_BYTES) ||
          !prefix_ok) begin
        res_o.verdict = VERDICT_INVALID;
      end else if (op_d == OPC_POLL) begin
        res_o.verdict = VERDICT_POLL;
      end else if (op_d == OPC_SYNC) begin
        if (refused) begin
          res_o.verdict = VERDICT_BC_REFUSE;
        end else begin
          res_o.verdict    = VERDICT_SYNC;
          res_o.sync_pulse = 1'b1;
          mode_d           = 1'b1;
          fed_d            = 1'b1;
          ticks_d          = '0;
        end
      end else if (data_op) begin
        if (refused) begin
          res_o.verdict = VERDICT_BC_REFUSE;
        end else if (total < (POS_W+1)'(HDR_BYTES)) begin
          res_o.verdict = VERDICT_INVALID;
        end else if (!fields_ok) begin
          res_o.verdict = VERDICT_FIELD_REJ;
        end else if ({5'd0, total} < ({1'b0, len_d} + 17'(HDR_BYTES))) begin
          res_o.verdict = VERDICT_INVALID;
        end else begin
          res_o.verdict         = (op_d == OPC_OUTPUT) ? VERDICT_OUTPUT_OK : VERDICT_NZS_OK;
          res_o.universe_number = uni_d[14:0];
          res_o.slot_count      = len_d[9:0];
          if (mode_q && starved) begin
            fed_d            = 1'b0;
            mode_d           = 1'b0;
            res_o.sync_pulse = 1'b1;
          end
        end
      end else begin
        res_o.verdict = VERDICT_OTHER;
      end
    end
    res_o.sync_mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sig_ok_q <= 1'b1;
      op_q     <= '0;
      ver_q    <= '0;
      sc_q     <= '0;
      uni_q    <= '0;
      len_q    <= '0;
      fed_q    <= 1'b0;
      ticks_q  <= '0;
      mode_q   <= 1'b0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      fed_q   <= fed_d;
      ticks_q <= ticks_d;
      mode_q  <= mode_d;
      if (item_i.action == ACT_BYTE && item_i.last_byte) begin
        sig_ok_q <= 1'b1;
        op_q     <= '0;
        ver_q    <= '0;
        sc_q     <= '0;
        uni_q    <= '0;
        len_q    <= '0;
      end else if (item_i.action == ACT_BYTE) begin
        sig_ok_q <= sig_ok_d;
        op_q     <= op_d;
        ver_q    <= ver_d;
        sc_q     <= sc_d;
        uni_q    <= uni_d;
        len_q    <= len_d;
      end
    end
  end

endmodule

FILE: hw/rtl/artnet_packet_filter.sv
// Art-Net receive filter top level: input register, parser core, result register.
// Takes one transaction per cycle (bytes or ticks) unless a stalled result blocks the input;
// the input register holds each accepted transaction while the combinational parse and
// watchdog logic feeds its result into the result register.
// Ticks and header bytes produce no result; payload bytes of an accepted ArtOutput or
// ArtNzs produce slot results, and the last byte of every packet produces one verdict.
// Configuration writes are always ready and should be issued only while the block is idle.
module artnet_packet_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_action_i,
  input  logic [7:0]                     in_data_byte_i,
  input  logic                           in_last_byte_i,
  input  logic                           in_broadcast_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           out_kind_o,
  output logic [2:0]                     out_verdict_o,
  output logic [14:0]                    out_universe_number_o,
  output logic [9:0]                     out_slot_count_o,
  output logic [8:0]                     out_slot_index_o,
  output logic [7:0]                     out_slot_value_o,
  output logic                           out_sync_pulse_o,
  output logic                           out_sync_mode_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [apf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [apf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import apf_pkg::*;

  logic  in_valid_q, in_valid_d;
  item_t in_item_q;
  logic  out_valid_q, out_valid_d;
  res_t  out_res_q;
  logic  advance, step, accept, res_valid;
  res_t  res;
  cfg_t  cfg;

  assign cfg_ready_o = 1'b1;

  apf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  apf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q.action    <= in_action_i;
      in_item_q.data_byte <= in_data_byte_i;
      in_item_q.last_byte <= in_last_byte_i;
      in_item_q.broadcast <= in_broadcast_i;
    end
    if (advance && step && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_kind_o            = out_res_q.kind;
  assign out_verdict_o         = out_res_q.verdict;
  assign out_universe_number_o = out_res_q.universe_number;
  assign out_slot_count_o      = out_res_q.slot_count;
  assign out_slot_index_o      = out_res_q.slot_index;
  assign out_slot_value_o      = out_res_q.slot_value;
  assign out_sync_pulse_o      = out_res_q.sync_pulse;
  assign out_sync_mode_o       = out_res_q.sync_mode;

  // slot transactions carry no verdict and never pulse sync
  a_slot_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_SLOT |->
      out_verdict_o == VERDICT_INVALID && !out_sync_pulse_o)
    else $error("slot result with verdict or sync pulse");

  a_pulse_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_sync_pulse_o |->
      out_verdict_o == VERDICT_SYNC || out_verdict_o == VERDICT_OUTPUT_OK ||
      out_verdict_o == VERDICT_NZS_OK)
    else $error("sync pulse on unexpected verdict");

  a_sync_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_VERDICT && out_verdict_o == VERDICT_SYNC |->
      out_sync_mode_o && out_sync_pulse_o)
    else $error("accepted sync did not enter sync mode");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_VERDICT &&
    (out_verdict_o == VERDICT_OUTPUT_OK || out_verdict_o == VERDICT_NZS_OK) |->
      out_slot_count_o >= 10'd2 && !out_slot_count_o[0])
    else $error("accepted output packet with bad slot count");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the Art-Net packet filter: directed and random packets, scoreboard.
module tb_top;
  import apf_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int STUCK_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 60;
  localparam int MAX_SHOWN     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [15:0] OPC_UNKNOWN = 16'h1234;
  localparam logic [15:0] OPC_ADDRESS = 16'h6000;

  typedef enum int {BC_NONE, BC_ALL, BC_RANDOM, BC_NOT_LAST, BC_ONLY_LAST} bc_mode_e;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  in_action = 1'b0;
  logic [7:0]            in_data   = 8'h00;
  logic                  in_last   = 1'b0;
  logic                  in_bcast  = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_kind;
  logic [2:0]            out_verdict;
  logic [14:0]           out_universe;
  logic [9:0]            out_count;
  logic [8:0]            out_index;
  logic [7:0]            out_value;
  logic                  out_pulse;
  logic                  out_mode;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  artnet_packet_filter dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .in_action_i           (in_action),
    .in_data_byte_i        (in_data),
    .in_last_byte_i        (in_last),
    .in_broadcast_i        (in_bcast),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .out_kind_o            (out_kind),
    .out_verdict_o         (out_verdict),
    .out_universe_number_o (out_universe),
    .out_slot_count_o      (out_count),
    .out_slot_index_o      (out_index),
    .out_slot_value_o      (out_value),
    .out_sync_pulse_o      (out_pulse),
    .out_sync_mode_o       (out_mode),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [7:0]  art_sig [0:7] = '{8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00};
  logic [15:0] std_ops [0:34] = '{
    16'h2000, 16'h2100, 16'h2300, 16'h2400, 16'h5000, 16'h5100, 16'h5200, 16'h6000,
    16'h7000, 16'h8000, 16'h8100, 16'h8200, 16'h8300, 16'h8400, 16'hA010, 16'hA020,
    16'hA040, 16'hF000, 16'hF100, 16'hF200, 16'hF300, 16'hF400, 16'hF500, 16'hF600,
    16'hF800, 16'hF900, 16'h9000, 16'h9100, 16'h9200, 16'h9300, 16'h9700, 16'h9800,
    16'h9900, 16'h9A00, 16'h9B00};

  // predictor configuration and state
  logic        allow_bcast = 1'b1;
  logic [15:0] min_ver     = 16'd14;
  logic [15:0] sync_limit  = 16'd4000;
  logic [10:0] rx_pos      = '0;
  logic        sig_good    = 1'b1;
  logic [15:0] op_word     = '0;
  logic [15:0] proto_ver   = '0;
  logic [7:0]  start_code  = '0;
  logic [15:0] univ_word   = '0;
  logic [15:0] slot_len    = '0;
  logic        wd_fed      = 1'b0;
  logic [15:0] sync_ticks  = '0;
  logic        in_sync     = 1'b0;

  res_t due_slot_verdicts[$];
  logic [7:0] pkt_buf[$];

  int  errors = 0;
  int  n_items = 0;
  int  n_ticks = 0;
  int  n_packets = 0;
  int  n_slots = 0;
  int  n_verdicts = 0;
  int  n_pulses = 0;
  int  stuck = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_len = 0;

  function automatic bit is_std_op(input logic [15:0] op);
    bit hit;
    hit = 1'b0;
    foreach (std_ops[i]) if (std_ops[i] == op) hit = 1'b1;
    return hit;
  endfunction

  task automatic parse_artnet_item(input item_t it);
    res_t r;
    int pi, total;
    bit pre_ok, data_op, refuse, fld_ok, slot_here;
    if (it.action == ACT_TICK) begin
      if (sync_ticks != 16'hFFFF) sync_ticks = sync_ticks + 16'd1;
      return;
    end
    pi = int'(rx_pos);
    if (pi < 8) begin
      if (it.data_byte != art_sig[pi]) sig_good = 1'b0;
    end else begin
      case (pi)
        8:  op_word[7:0]    = it.data_byte;
        9:  op_word[15:8]   = it.data_byte;
        10: proto_ver[15:8] = it.data_byte;
        11: proto_ver[7:0]  = it.data_byte;
        13: start_code      = it.data_byte;
        14: univ_word[7:0]  = it.data_byte;
        15: univ_word[15:8] = it.data_byte;
        16: slot_len[15:8]  = it.data_byte;
        17: slot_len[7:0]   = it.data_byte;
        default: ;
      endcase
    end
    pre_ok  = sig_good && is_std_op(op_word) && (proto_ver >= min_ver);
    data_op = (op_word == OPC_OUTPUT) || (op_word == OPC_NZS);
    refuse  = it.broadcast && !allow_bcast;
    fld_ok  = (slot_len >= 16'd2) && (int'(slot_len) <= int'(MAX_SLOTS)) && !slot_len[0] &&
              !univ_word[15] && !(op_word == OPC_NZS && start_code != 8'h00);
    slot_here = (pi >= int'(HDR_BYTES)) && pre_ok && data_op && !refuse && fld_ok &&
                ((pi - int'(HDR_BYTES)) < int'(slot_len));
    r = '0;
    if (!it.last_byte) begin
      if (rx_pos != 11'(POS_LIMIT)) rx_pos = rx_pos + 11'd1;
      if (slot_here) begin
        r.kind            = KIND_SLOT;
        r.verdict         = VERDICT_INVALID;
        r.universe_number = univ_word[14:0];
        r.slot_count      = slot_len[9:0];
        r.slot_index      = 9'(pi - int'(HDR_BYTES));
        r.slot_value      = it.data_byte;
        r.sync_mode       = in_sync;
        due_slot_verdicts.push_back(r);
      end
      return;
    end
    total = pi + 1;
    r.kind = KIND_VERDICT;
    if (slot_here) begin
      r.slot_index = 9'(pi - int'(HDR_BYTES));
      r.slot_value = it.data_byte;
    end
    if (total < int'(MIN_PKT_BYTES) || total > int'(MAX_PACKET_BYTES) || !pre_ok) begin
      r.verdict = VERDICT_INVALID;
    end else if (op_word == OPC_POLL) begin
      r.verdict = VERDICT_POLL;
    end else if (op_word == OPC_SYNC) begin
      if (refuse) begin
        r.verdict = VERDICT_BC_REFUSE;
      end else begin
        r.verdict    = VERDICT_SYNC;
        r.sync_pulse = 1'b1;
        in_sync      = 1'b1;
        wd_fed       = 1'b1;
        sync_ticks   = '0;
      end
    end else if (data_op) begin
      if (refuse) begin
        r.verdict = VERDICT_BC_REFUSE;
      end else if (total < int'(HDR_BYTES)) begin
        r.verdict = VERDICT_INVALID;
      end else if (!fld_ok) begin
        r.verdict = VERDICT_FIELD_REJ;
      end else if (total < int'(HDR_BYTES) + int'(slot_len)) begin
        r.verdict = VERDICT_INVALID;
      end else begin
        r.verdict         = (op_word == OPC_OUTPUT) ? VERDICT_OUTPUT_OK : VERDICT_NZS_OK;
        r.universe_number = univ_word[14:0];
        r.slot_count      = slot_len[9:0];
        if (in_sync && (!wd_fed || sync_ticks > sync_limit)) begin
          wd_fed       = 1'b0;
          r.sync_pulse = 1'b1;
          in_sync      = 1'b0;
        end
      end
    end else begin
      r.verdict = VERDICT_OTHER;
    end
    rx_pos     = '0;
    sig_good   = 1'b1;
    op_word    = '0;
    proto_ver  = '0;
    start_code = '0;
    univ_word  = '0;
    slot_len   = '0;
    r.sync_mode = in_sync;
    due_slot_verdicts.push_back(r);
  endtask

  function automatic string show(input res_t r);
    return $sformatf("kind=%0d verdict=%0d univ=%0d count=%0d index=%0d value=%0d pulse=%0d mode=%0d",
                     r.kind, r.verdict, r.universe_number, r.slot_count, r.slot_index,
                     r.slot_value, r.sync_pulse, r.sync_mode);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_valid && !out_stall) begin
      got.kind            = out_kind;
      got.verdict         = verdict_e'(out_verdict);
      got.universe_number = out_universe;
      got.slot_count      = out_count;
      got.slot_index      = out_index;
      got.slot_value      = out_value;
      got.sync_pulse      = out_pulse;
      got.sync_mode       = out_mode;
      if (out_kind == KIND_VERDICT) n_verdicts++; else n_slots++;
      if (out_pulse) n_pulses++;
      if (due_slot_verdicts.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("unexpected result: %s", show(got));
      end else begin
        want = due_slot_verdicts.pop_front();
        if (got.kind !== want.kind || got.verdict !== want.verdict ||
            got.universe_number !== want.universe_number ||
            got.slot_count !== want.slot_count || got.slot_index !== want.slot_index ||
            got.slot_value !== want.slot_value || got.sync_pulse !== want.sync_pulse ||
            got.sync_mode !== want.sync_mode) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("mismatch at %0t", $time);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // receiver: random stall bursts plus requested long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b, input logic last,
                           input logic bc);
    item_t it;
    if (tx_idle_on && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_data   <= b;
    in_last   <= last;
    in_bcast  <= bc;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    it.action    = act;
    it.data_byte = b;
    it.last_byte = last;
    it.broadcast = bc;
    parse_artnet_item(it);
    n_items++;
    if (act == ACT_TICK) n_ticks++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_slot_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      REG_BCAST_ALLOWED: allow_bcast = data[0];
      REG_MIN_VERSION:   min_ver     = data;
      REG_SYNC_TIMEOUT:  sync_limit  = data;
      default: ;
    endcase
  endtask

  task automatic cfg_apply(input logic bc_ok, input logic [15:0] ver, input logic [15:0] tmo);
    cfg_write(REG_BCAST_ALLOWED, {15'($urandom_range(0, 32767)), bc_ok});
    cfg_write(REG_MIN_VERSION, ver);
    cfg_write(REG_SYNC_TIMEOUT, tmo);
    cfg_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  task automatic build_hdr(input logic [15:0] op, input logic [15:0] ver, input logic [7:0] sc,
                           input logic [15:0] uni, input logic [15:0] len);
    pkt_buf.delete();
    foreach (art_sig[i]) pkt_buf.push_back(art_sig[i]);
    pkt_buf.push_back(op[7:0]);
    pkt_buf.push_back(op[15:8]);
    pkt_buf.push_back(ver[15:8]);
    pkt_buf.push_back(ver[7:0]);
    pkt_buf.push_back(8'($urandom_range(0, 255)));
    pkt_buf.push_back(sc);
    pkt_buf.push_back(uni[7:0]);
    pkt_buf.push_back(uni[15:8]);
    pkt_buf.push_back(len[15:8]);
    pkt_buf.push_back(len[7:0]);
  endtask

  task automatic add_bytes(input int n);
    repeat (n) pkt_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic trim_to(input int n);
    while (pkt_buf.size() > n) void'(pkt_buf.pop_back());
  endtask

  task automatic data_pkt(input logic [15:0] op, input logic [15:0] ver, input logic [15:0] uni,
                          input logic [15:0] len, input logic [7:0] sc, input int ndata);
    build_hdr(op, ver, sc, uni, len);
    add_bytes(ndata);
  endtask

  task automatic send_packet(input bc_mode_e mode, input int tick_pct);
    int n;
    logic bc;
    n = pkt_buf.size();
    for (int i = 0; i < n; i++) begin
      case (mode)
        BC_NONE:     bc = 1'b0;
        BC_ALL:      bc = 1'b1;
        BC_RANDOM:   bc = 1'($urandom_range(0, 1));
        BC_NOT_LAST: bc = (i != n - 1);
        default:     bc = (i == n - 1);
      endcase
      if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct) send_ticks(1);
      send_item(ACT_BYTE, pkt_buf[i], i == n - 1, bc);
    end
    n_packets++;
  endtask

  task automatic test_header_checks();
    build_hdr(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000);
    trim_to(11);
    send_packet(BC_NONE, 0);
    pkt_buf.delete();
    pkt_buf.push_back(art_sig[0]);
    send_packet(BC_NONE, 0);
    build_hdr(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000);
    trim_to(12);
    send_packet(BC_NONE, 0);
    build_hdr(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000);
    pkt_buf[3] = 8'h00;
    trim_to(14);
    send_packet(BC_NONE, 0);
    build_hdr(OPC_UNKNOWN, 16'd14, 8'h00, 16'h0000, 16'h0000);
    trim_to(14);
    send_packet(BC_NONE, 0);
    build_hdr(OPC_POLL, 16'd13, 8'h00, 16'h0000, 16'h0000);
    trim_to(14);
    send_packet(BC_NONE, 0);
    build_hdr(OPC_POLL, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    trim_to(14);
    send_packet(BC_ALL, 0);
    send_ticks(3);
    build_hdr(OPC_ADDRESS, 16'd14, 8'h00, 16'h0000, 16'h0000);
    send_packet(BC_NONE, 0);
    build_hdr(OPC_SYNC, 16'd14, 8'h00, 16'h0000, 16'h0000);
    trim_to(14);
    send_packet(BC_ALL, 0);
  endtask

  task automatic test_data_fields();
    data_pkt(OPC_OUTPUT, 16'd14, 16'h7FFF, 16'd2, 8'h00, 2);
    pkt_buf[18] = 8'hFF;
    pkt_buf[19] = 8'h00;
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'h0000, 16'd512, 8'h00, 515);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd5, 16'd0, 8'h00, 0);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd5, 16'd1, 8'h00, 1);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd5, 16'd514, 8'h00, 4);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'h8000, 16'd2, 8'h00, 2);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_NZS, 16'd14, 16'd3, 16'd4, 8'h01, 4);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_NZS, 16'd14, 16'd3, 16'd6, 8'h00, 6);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd1, 16'd2, 8'h00, 2);
    trim_to(17);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd1, 16'd8, 8'h00, 4);
    send_packet(BC_NONE, 0);
  endtask

  task automatic test_broadcast_refusal();
    wait_drained();
    cfg_apply(1'b0, 16'd14, 16'd4000);
    build_hdr(OPC_SYNC, 16'd14, 8'h00, 16'h0000, 16'h0000);
    trim_to(14);
    send_packet(BC_ALL, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd9, 16'd4, 8'h00, 4);
    send_packet(BC_ALL, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd9, 16'd3, 8'h00, 3);
    send_packet(BC_ALL, 0);
    build_hdr(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000);
    trim_to(11);
    send_packet(BC_ALL, 0);
    build_hdr(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000);
    send_packet(BC_ALL, 0);
    data_pkt(OPC_NZS, 16'd14, 16'd10, 16'd6, 8'h00, 6);
    send_packet(BC_NOT_LAST, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd11, 16'd6, 8'h00, 6);
    send_packet(BC_ONLY_LAST, 0);
    data_pkt(OPC_OUTPUT, 16'd14, 16'd12, 16'd8, 8'h00, 8);
    send_packet(BC_RANDOM, 0);
  endtask

  task automatic test_sync_watchdog();
    wait_drained();
    cfg_apply(1'b1, 16'd0, 16'd1);
    build_hdr(OPC_SYNC, 16'd0, 8'h00, 16'h0000, 16'h0000);
    trim_to(14);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'd0, 16'd1, 16'd2, 8'h00, 2);
    send_packet(BC_NONE, 0);
    send_ticks(2);
    data_pkt(OPC_OUTPUT, 16'd0, 16'd1, 16'd2, 8'h00, 2);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_NZS, 16'd0, 16'd1, 16'd2, 8'h00, 2);
    send_packet(BC_NONE, 0);
    build_hdr(OPC_SYNC, 16'd0, 8'h00, 16'h0000, 16'h0000);
    send_packet(BC_NONE, 0);
    send_ticks(1);
    data_pkt(OPC_OUTPUT, 16'd0, 16'd2, 16'd2, 8'h00, 2);
    send_packet(BC_NONE, 0);
    wait_drained();
    cfg_apply(1'b1, 16'hFFFF, 16'd20);
    build_hdr(OPC_SYNC, 16'hFFFF, 8'h00, 16'h0000, 16'h0000);
    trim_to(14);
    send_packet(BC_NONE, 0);
    tx_idle_on = 1'b0;
    send_ticks(20);
    tx_idle_on = 1'b1;
    data_pkt(OPC_OUTPUT, 16'hFFFF, 16'd3, 16'd2, 8'h00, 2);
    send_packet(BC_NONE, 0);
    send_ticks(1);
    data_pkt(OPC_OUTPUT, 16'hFFFE, 16'd3, 16'd2, 8'h00, 2);
    send_packet(BC_NONE, 0);
    data_pkt(OPC_OUTPUT, 16'hFFFF, 16'd4, 16'd2, 8'h00, 2);
    send_packet(BC_NONE, 0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    cfg_apply(1'b1, 16'd14, 16'd4000);
    tx_idle_on = 1'b0;
    hold_len = 150;
    hold_req = 1'b1;
    data_pkt(OPC_OUTPUT, 16'd14, 16'($urandom_range(0, 32767)), 16'd64, 8'h00, 64);
    send_packet(BC_NONE, 0);
    while (hold_req) @(posedge clk_i);
    wait_drained();
    data_pkt(OPC_NZS, 16'd14, 16'($urandom_range(0, 32767)), 16'd16, 8'h00, 16);
    send_packet(BC_NONE, 0);
    tx_idle_on = 1'b1;
  endtask

  task automatic random_packet();
    int sel, r, len, ndata;
    logic [15:0] ver, uni, op;
    logic [7:0] sc;
    bc_mode_e mode;
    sel = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (r < 80) ver = 16'(14 + $urandom_range(0, 3));
    else if (r < 88) ver = 16'hFFFF;
    else if (r < 94) ver = 16'h0000;
    else ver = 16'($urandom_range(0, 65535));
    if (sel < 65) begin
      op = $urandom_range(0, 1) ? OPC_OUTPUT : OPC_NZS;
      r = $urandom_range(0, 99);
      if (r < 85) len = 2 * $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(0, 20);
      else if (r < 98) len = 512;
      else len = $urandom_range(513, 65535);
      uni = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 32767)) :
                                          16'($urandom_range(32768, 65535));
      sc = ($urandom_range(0, 9) != 0) ? 8'h00 : 8'($urandom_range(1, 255));
      ndata = (len <= 512) ? len : $urandom_range(0, 6);
      data_pkt(op, ver, uni, 16'(len), sc, ndata);
      if (sel >= 55) pkt_buf[$urandom_range(0, 17)] = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 10) add_bytes($urandom_range(1, 4));
      else if (r < 17) trim_to($urandom_range(1, pkt_buf.size()));
    end else if (sel < 75) begin
      build_hdr(OPC_SYNC, ver, 8'h00, 16'h0000, 16'h0000);
      trim_to(12 + $urandom_range(0, 6));
    end else if (sel < 80) begin
      build_hdr(OPC_POLL, ver, 8'h00, 16'h0000, 16'h0000);
      trim_to(12 + $urandom_range(0, 6));
    end else if (sel < 87) begin
      build_hdr(std_ops[$urandom_range(0, 34)], ver, 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      add_bytes($urandom_range(0, 6));
    end else begin
      pkt_buf.delete();
      add_bytes($urandom_range(1, 40));
      if ($urandom_range(0, 1) && pkt_buf.size() >= 8)
        foreach (art_sig[i]) pkt_buf[i] = art_sig[i];
    end
    r = $urandom_range(0, 99);
    if (r < 70) mode = BC_NONE;
    else if (r < 85) mode = BC_ALL;
    else if (r < 93) mode = BC_RANDOM;
    else if (r < 97) mode = BC_NOT_LAST;
    else mode = BC_ONLY_LAST;
    send_packet(mode, 3);
    r = $urandom_range(0, 99);
    if (r < 50) send_ticks($urandom_range(0, 2));
    else if (r < 55) send_ticks($urandom_range(10, 60));
  endtask

  task automatic test_random_traffic();
    int start;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: cfg_apply(1'b1, 16'd14, 16'($urandom_range(1, 30)));
        1: cfg_apply(1'b0, 16'd0, 16'd1);
        2: cfg_apply(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16)), 16'hFFFF);
        default: cfg_apply(1'b1, 16'd14, 16'($urandom_range(2, 20)));
      endcase
      tx_idle_on = (ph != 3);
      rx_idle_on = (ph != 3);
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        if (ph != 3) begin
          tx_idle_on = ($urandom_range(0, 3) != 0);
          rx_idle_on = ($urandom_range(0, 3) != 0);
        end
        random_packet();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_header_checks();
    test_data_fields();
    test_broadcast_refusal();
    test_sync_watchdog();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (due_slot_verdicts.size() != 0) begin
      $display("%0d results never arrived", due_slot_verdicts.size());
      errors += due_slot_verdicts.size();
    end
    $display("Summary: %0d packets, %0d items (%0d ticks) sent; %0d slots, %0d verdicts checked",
             n_packets, n_items, n_ticks, n_slots, n_verdicts);
    $display("Summary: %0d sync pulses seen, %0d failures", n_pulses, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/apf_pkg.sv
hw/rtl/apf_cfg.sv
hw/rtl/apf_core.sv
hw/rtl/artnet_packet_filter.sv
test/tb_top.sv
